// ===== hw/rtl/json_string_escaper_core_defines.svh =====
// assertion macros for the json string escaper core
// used by the top level only, which supplies clk and arst_n in scope
`ifndef JSON_STRING_ESCAPER_CORE_DEFINES_SVH
`define JSON_STRING_ESCAPER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define JSE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jse: same-cycle property violated");

// next-cycle implication, disabled while in reset
`define JSE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jse: next-cycle property violated");

`endif

// ===== hw/rtl/jse_pkg.sv =====
// shared types, constants and helpers for the json string escaper core
// no dependencies
package jse_pkg;

	localparam int unsigned JSE_QUEUE_DEPTH = 4;
	localparam int unsigned RUN_MAX = 6;
	localparam int unsigned STEP_W = $clog2(RUN_MAX);

	localparam logic [15:0] CAP_RESET = 16'd256;
	localparam logic [16:0] ESC_ROOM = 17'd6;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	typedef enum logic [1:0] {
		KIND_PASS,
		KIND_PAIR,
		KIND_UNI
	} jse_kind_t;

	// one classified byte waiting for the back end
	typedef struct packed {
		jse_kind_t   kind;
		logic [7:0]  ch;
		logic [15:0] base_idx;
	} jse_entry_t;

	function automatic logic [7:0] hex_lower(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CH_ZERO + {4'd0, nib};
		end else begin
			r = CH_LOWER_A + {4'd0, nib} - 8'd10;
		end
		return r;
	endfunction

	function automatic logic [STEP_W-1:0] run_len(input jse_kind_t kind);
		logic [STEP_W-1:0] r;
		case (kind)
			KIND_PASS: r = STEP_W'(1);
			KIND_PAIR: r = STEP_W'(2);
			KIND_UNI:  r = STEP_W'(RUN_MAX);
			default:   r = STEP_W'(1);
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/jse_queue.sv =====
// small register queue between the front and back ends
// depends on jse_pkg for the entry type
module jse_queue import jse_pkg::*; #(
	parameter int unsigned DEPTH = JSE_QUEUE_DEPTH,
	localparam int unsigned PTR_W = $clog2(DEPTH),
	localparam int unsigned LVL_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jse_entry_t       push_entry,
	input  logic             pop,
	output jse_entry_t       head,
	output logic             full,
	output logic             empty,
	output logic [LVL_W-1:0] level
);

	jse_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	assign full = (level_q == LVL_W'(DEPTH));
	assign empty = (level_q == '0);
	assign level = level_q;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + LVL_W'(1);
				2'b01:   level_q <= level_q - LVL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/jse_front.sv =====
// front end: capacity register, string count and stop state, byte classification
// depends on jse_pkg; feeds jse_queue
module jse_front import jse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        string_start,
	input  logic        q_full,
	output logic        push,
	output jse_entry_t  push_entry
);

	logic [15:0] capacity_q;
	logic [15:0] out_count_q;
	logic        stopped_q;

	logic        in_fire;
	logic [15:0] cnt;
	logic        stp;
	logic        room;
	logic        emit;
	jse_kind_t   kind;
	logic [7:0]  ch;

	assign in_ready = !q_full;
	assign in_fire = in_valid && in_ready;

	// a start flag clears count and stop before the byte is looked at
	assign cnt = string_start ? 16'd0 : out_count_q;
	assign stp = string_start ? 1'b0 : stopped_q;
	assign room = ({1'b0, cnt} + ESC_ROOM) < {1'b0, capacity_q};
	assign emit = !stp && (data_byte != 8'd0) && room;

	always_comb begin
		kind = KIND_PASS;
		ch = data_byte;
		case (data_byte)
			CH_QUOTE, CH_BSLASH: begin
				kind = KIND_PAIR;
			end
			CH_LF: begin
				kind = KIND_PAIR;
				ch = CH_N;
			end
			CH_CR: begin
				kind = KIND_PAIR;
				ch = CH_R;
			end
			CH_TAB: begin
				kind = KIND_PAIR;
				ch = CH_T;
			end
			default: begin
				if (data_byte < CTRL_LIMIT) begin
					kind = KIND_UNI;
				end
			end
		endcase
	end

	assign push = in_fire && emit;
	assign push_entry = '{kind: kind, ch: ch, base_idx: cnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			out_count_q <= '0;
			stopped_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (in_fire) begin
				out_count_q <= emit ? cnt + {{(16 - STEP_W){1'b0}}, run_len(kind)} : cnt;
				stopped_q <= !emit;
			end
		end
	end

endmodule

// ===== hw/rtl/jse_back.sv =====
// back end: walks each queued entry through its escape run into the output register
// depends on jse_pkg; drains jse_queue
module jse_back import jse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  jse_entry_t  head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [15:0] out_index,
	output logic        last_of_run
);

	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [15:0]       out_index_q;
	logic              out_last_q;

	logic              load;
	logic              is_last;
	logic [7:0]        byte_sel;

	assign load = !q_empty && (!out_valid_q || out_ready);
	assign is_last = (step_q == run_len(head.kind) - STEP_W'(1));
	assign pop = load && is_last;

	always_comb begin
		byte_sel = head.ch;
		case (head.kind)
			KIND_PASS: byte_sel = head.ch;
			KIND_PAIR: byte_sel = (step_q == '0) ? CH_BSLASH : head.ch;
			KIND_UNI: begin
				case (step_q)
					STEP_W'(0): byte_sel = CH_BSLASH;
					STEP_W'(1): byte_sel = CH_U;
					STEP_W'(2): byte_sel = CH_ZERO;
					STEP_W'(3): byte_sel = CH_ZERO;
					STEP_W'(4): byte_sel = hex_lower(head.ch[7:4]);
					default:    byte_sel = hex_lower(head.ch[3:0]);
				endcase
			end
			default: byte_sel = head.ch;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= byte_sel;
			out_index_q <= head.base_idx + {{(16 - STEP_W){1'b0}}, step_q};
			out_last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= is_last ? '0 : step_q + STEP_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_index = out_index_q;
	assign last_of_run = out_last_q;

endmodule

// ===== hw/rtl/json_string_escaper_core.sv =====
// top level of the json string escaper core: front end, queue, back end
// depends on jse_pkg, jse_front, jse_queue, jse_back and the defines header
//
//   channel   handshake             payload
//   config    cfg_we                cfg_wdata (out_capacity)
//   input     in_valid / in_ready   data_byte, string_start
//   output    out_valid / out_ready out_byte, out_index, last_of_run
//
// while out_ready is high, one output beat per cycle from the back end; a plain
// byte is one beat, a two-char escape two, a \u00xx escape six, dropped bytes none
// the front takes one input beat per cycle while the queue has room
// (QUEUE_DEPTH entries), so long escape runs back it up only through the queue
// an accepted input beat is written into the queue and then loaded from the queue
// head into the output register, where its first output beat can be taken
// arst_n clears count, stop flag, queue and output valid; capacity resets to 256
`include "json_string_escaper_core_defines.svh"

module json_string_escaper_core import jse_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = JSE_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        string_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [15:0] out_index,
	output logic        last_of_run
);

	localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

	logic             q_push;
	jse_entry_t       q_push_entry;
	logic             q_pop;
	jse_entry_t       q_head;
	logic             q_full;
	logic             q_empty;
	logic [LVL_W-1:0] q_level;

	jse_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.string_start (string_start),
		.q_full       (q_full),
		.push         (q_push),
		.push_entry   (q_push_entry)
	);

	jse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.pop        (q_pop),
		.head       (q_head),
		.full       (q_full),
		.empty      (q_empty),
		.level      (q_level)
	);

	jse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head        (q_head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.out_index   (out_index),
		.last_of_run (last_of_run)
	);

	// a run that is not finished keeps the output busy with the next index
	`JSE_ASSERT_NXT(a_run_continues, out_valid && out_ready && !last_of_run, out_valid && (out_index == $past(out_index) + 16'd1))
	// queue occupancy never exceeds its depth
	`JSE_ASSERT_IMP(a_queue_bound, 1'b1, q_level <= LVL_W'(QUEUE_DEPTH))
	// the back end only retires an entry that is present
	`JSE_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// testbench for json_string_escaper_core: sends strings byte by byte and checks every escaped beat
// against a behavioral escaper that runs alongside; depends on jse_pkg and the core rtl

module tb import jse_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_ITEMS = 90;
	localparam int PHASES = 6;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [7:0]  ch;
		logic [15:0] idx;
		logic        last;
	} esc_beat_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_COIN,
		RX_CADENCE,
		RX_SPARSE
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        string_start = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic [15:0] out_index;
	logic        last_of_run;

	// escaper state as seen from outside
	logic [15:0] model_capacity = CAP_RESET;
	logic [15:0] model_count = '0;
	bit          model_stopped = 1'b0;
	esc_beat_t   escaped_q [$];

	int       errors;
	int       beats_checked;
	int       items_sent;
	int       live_items;
	int       cut_strings;
	int       burst_left;
	bit       steady;
	int       hold_requests;
	int       holds_served;
	int       hold_left;
	int       rx_tick;
	rx_mode_t rx_mode = RX_FREE;
	int       idle_cycles;

	json_string_escaper_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.string_start (string_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.out_index    (out_index),
		.last_of_run  (last_of_run)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		if (errors < MAX_PRINTED) begin
			$display("mismatch @%0t: %s", $realtime, what);
		end
		errors++;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + 8'(nib);
		end else begin
			c = CH_LOWER_A + 8'(nib) - 8'd10;
		end
		return c;
	endfunction

	// works out the escaped beats for one accepted input beat
	task automatic escape_model(input logic [7:0] b, input logic s, output bit live);
		logic [7:0] chars [0:5];
		int n;
		esc_beat_t beat;
		n = 0;
		if (s) begin
			model_count = '0;
			model_stopped = 1'b0;
		end
		live = !model_stopped;
		if (!model_stopped) begin
			if (b == 8'h00) begin
				model_stopped = 1'b1;
			end else if ({1'b0, model_count} + ESC_ROOM >= {1'b0, model_capacity}) begin
				// no room left: rest of the string is dropped
				model_stopped = 1'b1;
				cut_strings++;
			end else begin
				chars[0] = CH_BSLASH;
				n = 2;
				case (b)
					CH_QUOTE, CH_BSLASH: chars[1] = b;
					CH_LF: chars[1] = CH_N;
					CH_CR: chars[1] = CH_R;
					CH_TAB: chars[1] = CH_T;
					default: begin
						if (b < CTRL_LIMIT) begin
							chars[1] = CH_U;
							chars[2] = CH_ZERO;
							chars[3] = CH_ZERO;
							chars[4] = hex_char(b[7:4]);
							chars[5] = hex_char(b[3:0]);
							n = 6;
						end else begin
							chars[0] = b;
							n = 1;
						end
					end
				endcase
				for (int k = 0; k < n; k++) begin
					beat.ch = chars[k];
					beat.idx = model_count + 16'(k);
					beat.last = (k == n - 1);
					escaped_q.push_back(beat);
				end
				model_count = model_count + 16'(n);
			end
		end
	endtask

	// offers one input beat, pacing the sender in bursts
	task automatic send_char(input logic [7:0] b, input logic s);
		bit live;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = steady ? 0 : $urandom_range(0, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		string_start <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		escape_model(b, s, live);
		items_sent++;
		if (live) begin
			live_items++;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (escaped_q.size() != 0) @(posedge clk);
		// dropped bytes leave no beat behind, give them time to clear the pipe
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] cap);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_capacity = cap;
	endtask

	function automatic logic [7:0] pick_char();
		int sel;
		logic [7:0] c;
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			c = 8'($urandom_range(8'h20, 8'h7e));
		end else if (sel < 50) begin
			c = $urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH;
		end else if (sel < 65) begin
			case ($urandom_range(0, 2))
				0: c = CH_LF;
				1: c = CH_CR;
				default: c = CH_TAB;
			endcase
		end else if (sel < 85) begin
			c = 8'($urandom_range(1, 8'h1f));
		end else begin
			c = 8'($urandom_range(8'h80, 8'hff));
		end
		return c;
	endfunction

	task automatic send_text(input int len, input bit terminate);
		for (int i = 0; i < len; i++) begin
			send_char(pick_char(), i == 0);
		end
		if (terminate) begin
			send_char(8'h00, 1'b0);
		end
	endtask

	task automatic test_escapes();
		send_char(8'h41, 1'b0);  // no start seen since reset
		send_char(8'h42, 1'b1);
		send_char(CH_QUOTE, 1'b0);
		send_char(CH_BSLASH, 1'b0);
		send_char(CH_LF, 1'b0);
		send_char(CH_CR, 1'b0);
		send_char(CH_TAB, 1'b0);
		send_char(8'h01, 1'b0);
		send_char(8'h1a, 1'b0);
		send_char(8'h1f, 1'b0);
		send_char(8'h20, 1'b0);
		send_char(8'h7e, 1'b0);
		send_char(8'h7f, 1'b0);
		send_char(8'h80, 1'b0);
		send_char(8'hff, 1'b0);
		send_char(8'h00, 1'b0);
		// bytes past the end of the string
		send_char(8'h78, 1'b0);
		send_char(8'h79, 1'b0);
		// start on a zero byte ends the string at once
		send_char(8'h00, 1'b1);
		send_char(8'h7a, 1'b0);
		send_char(8'h55, 1'b1);
		send_char(8'haa, 1'b0);
		send_char(8'h00, 1'b0);
	endtask

	task automatic test_truncation();
		write_capacity(16'd7);
		send_char(8'h61, 1'b1);
		send_char(8'h62, 1'b0);
		// more room does not revive a cut string
		write_capacity(16'd300);
		send_char(8'h63, 1'b0);
		send_char(8'h64, 1'b1);
		write_capacity(16'd1);
		send_char(8'h61, 1'b1);
		send_char(8'h01, 1'b0);
		write_capacity(16'd0);
		send_char(8'h71, 1'b1);
		write_capacity(16'd13);
		send_char(8'h01, 1'b1);
		send_char(8'h02, 1'b0);
		send_char(8'h03, 1'b0);
		send_char(8'h04, 1'b0);
		write_capacity(16'hffff);
		send_char(8'h4d, 1'b1);
		send_char(CH_QUOTE, 1'b0);
		send_char(8'h00, 1'b0);
	endtask

	// long receiver hold-off while control bytes, mostly six-beat escapes, keep coming
	task automatic test_backpressure();
		write_capacity(CAP_RESET);
		steady = 1'b1;
		hold_requests++;
		send_char(8'h01, 1'b1);
		for (int i = 0; i < 24; i++) begin
			send_char(8'($urandom_range(1, 8'h1f)), 1'b0);
		end
		send_char(8'h00, 1'b0);
		steady = 1'b0;
	endtask

	task automatic test_random_strings();
		logic [15:0] caps [0:PHASES-1];
		int target;
		int len;
		caps[0] = 16'($urandom_range(7, 40));
		caps[1] = CAP_RESET;
		caps[2] = 16'hffff;
		caps[3] = 16'($urandom_range(1, 65535));
		caps[4] = 16'($urandom_range(8, 120));
		caps[5] = 16'd7;
		target = items_sent;
		for (int p = 0; p < PHASES; p++) begin
			write_capacity(caps[p]);
			steady = (p == 2);
			target += RANDOM_ITEMS / PHASES;
			while (items_sent < target) begin
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 4)) begin
						send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
					end
				end else begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 12);
					send_text(len, $urandom_range(0, 7) != 0);
				end
			end
		end
		steady = 1'b0;
	endtask

	// receiver: changing stall pattern, plus long hold-offs on request
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_tick % 64 == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
		end
		if (holds_served != hold_requests) begin
			holds_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE: out_ready <= 1'b1;
				RX_COIN: out_ready <= 1'($urandom_range(0, 1));
				RX_CADENCE: out_ready <= (rx_tick % 3 != 0);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		esc_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (escaped_q.size() == 0) begin
				report_mismatch($sformatf("unexpected beat %02h at index %0d",
					out_byte, out_index));
			end else begin
				want = escaped_q.pop_front();
				beats_checked++;
				if (out_byte !== want.ch) begin
					report_mismatch($sformatf("index %0d: byte %02h, want %02h",
						want.idx, out_byte, want.ch));
				end
				if (out_index !== want.idx) begin
					report_mismatch($sformatf("out_index %0d, want %0d", out_index, want.idx));
				end
				if (last_of_run !== want.last) begin
					report_mismatch($sformatf("index %0d: last_of_run %b, want %b",
						want.idx, last_of_run, want.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles, %0d beats outstanding",
				idle_cycles, escaped_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_escapes();
		test_truncation();
		test_backpressure();
		test_random_strings();
		drain();
		if (escaped_q.size() != 0) begin
			report_mismatch($sformatf("%0d expected beats never came", escaped_q.size()));
		end
		$display("run: %0d input beats (%0d inside live strings), %0d output beats checked",
			items_sent, live_items, beats_checked);
		$display("run: %0d strings cut at capacity, %0d long output hold-offs, %0d mismatches",
			cut_strings, holds_served, errors);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
